// ----- hdl/interval_time_binning_top_macros.svh -----
// Assertion macros of the interval time binning RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTERVAL_TIME_BINNING_TOP_MACROS_SVH
`define INTERVAL_TIME_BINNING_TOP_MACROS_SVH

// same-cycle implication
`define ITB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/itb_pkg.sv -----
// Types, constants and codes of the interval time binning block.
// No dependencies.
package itb_pkg;

    localparam int MAX_INTERVALS = 256;
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;
    localparam int NUM_METHODS   = 16;
    localparam int METH_W        = 4;
    localparam int NUM_BINS      = 64;
    localparam int BIN_W         = 6;
    localparam int USED_W        = 7;
    localparam int TAB_DEPTH     = NUM_METHODS * NUM_BINS;
    localparam int TAB_W         = METH_W + BIN_W;
    localparam int TIME_W        = 31;
    localparam int WIDE_W        = 33;
    localparam int SIZE_W        = 21;
    localparam int TOTAL_W       = 32;
    localparam int ADDR_W        = 3;

    localparam logic [ADDR_W-1:0] REG_BIN_SIZE = 3'd0;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_NOT_FIN  = 2'd3;

    typedef struct packed {
        logic load;        // latch accepted beat
        logic rec;         // store interval
        logic clr;         // empty interval store
        logic rd_cap;      // capture table read result
        logic sweep_init;  // start finish
        logic sweep;       // clear one table entry
        logic used_step;   // one step of bin count
        logic int_rd;      // read interval k
        logic int_load;    // latch interval k
        logic bin_rd;      // read table entry, compute overlap
        logic bin_wr;      // write saturated sum, advance bin
        logic fin_done;    // finish result
        logic out_load;    // move result to output register
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic sweep_last;
        logic used_done;
        logic count_zero;
        logic b_last;
        logic k_last;
    } t_sts;

endpackage

// ----- hdl/itb_if.sv -----
// Valid/ready channel interfaces of the interval time binning block.
// Depends on itb_pkg.
interface itb_in_if;
    import itb_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [METH_W-1:0]   method_slot;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
    logic [BIN_W-1:0]    bin_index;
    modport source (output valid, opcode, method_slot, start_time, end_time, bin_index,
                    input ready);
    modport sink   (input valid, opcode, method_slot, start_time, end_time, bin_index,
                    output ready);
endinterface

interface itb_out_if;
    import itb_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [TOTAL_W-1:0]  bin_total;
    logic [USED_W-1:0]   bins_used;
    modport source (output valid, status, bin_total, bins_used, input ready);
    modport sink   (input valid, status, bin_total, bins_used, output ready);
endinterface

// ----- hdl/itb_ctrl.sv -----
// Sequencer of the interval time binning block: issues datapath commands.
// Depends on itb_pkg and the assertion macro header.
`include "interval_time_binning_top_macros.svh"

module itb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output itb_pkg::t_cmd o_cmd,
    input  itb_pkg::t_sts i_sts
);
    import itb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RDW, S_SWEEP, S_USED, S_IFETCH, S_ILOAD, S_BRD, S_BWR,
        S_FDONE, S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_RECORD: begin
                        cmd.rec = 1'b1;
                        n_state = S_RESP;
                    end
                    OP_CLEAR: begin
                        cmd.clr = 1'b1;
                        n_state = S_RESP;
                    end
                    OP_READ:   n_state = S_RDW;
                    OP_FINISH: begin
                        cmd.sweep_init = 1'b1;
                        n_state        = S_SWEEP;
                    end
                    default:   n_state = S_RESP;
                endcase
            end
            S_RDW: begin
                cmd.rd_cap = 1'b1;
                n_state    = S_RESP;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (i_sts.sweep_last) n_state = S_USED;
            end
            S_USED: begin
                cmd.used_step = 1'b1;
                if (i_sts.used_done || i_sts.count_zero) begin
                    n_state = i_sts.count_zero ? S_FDONE : S_IFETCH;
                end
            end
            S_IFETCH: begin
                cmd.int_rd = 1'b1;
                n_state    = S_ILOAD;
            end
            S_ILOAD: begin
                cmd.int_load = 1'b1;
                n_state      = S_BRD;
            end
            S_BRD: begin
                cmd.bin_rd = 1'b1;
                n_state    = S_BWR;
            end
            S_BWR: begin
                cmd.bin_wr = 1'b1;
                if (!i_sts.b_last)     n_state = S_BRD;
                else if (i_sts.k_last) n_state = S_FDONE;
                else                   n_state = S_IFETCH;
            end
            S_FDONE: begin
                cmd.fin_done = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                // wait for the previous result to leave the output register
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ITB_ASSERT_NXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "item overlap")
    `ITB_ASSERT_NXT(a_resp_out, cmd.out_load, r_out_valid && r_state == S_IDLE,
        "result not presented")
    `ITB_ASSERT_NXT(a_rmw_pair, cmd.bin_rd, cmd.bin_wr, "table update split")

endmodule

// ----- hdl/itb_dp.sv -----
// Datapath of the interval time binning block: interval store, time table,
// span tracking, bin walk and result registers. Depends on itb_pkg.
module itb_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  itb_pkg::t_cmd                   i_cmd,
    output itb_pkg::t_sts                   o_sts,
    input  logic [itb_pkg::SIZE_W-1:0]      i_bin_size,
    input  logic [1:0]                      i_opcode,
    input  logic [itb_pkg::METH_W-1:0]      i_method_slot,
    input  logic [itb_pkg::TIME_W-1:0]      i_start_time,
    input  logic [itb_pkg::TIME_W-1:0]      i_end_time,
    input  logic [itb_pkg::BIN_W-1:0]       i_bin_index,
    output logic [1:0]                      o_status,
    output logic [itb_pkg::TOTAL_W-1:0]     o_bin_total,
    output logic [itb_pkg::USED_W-1:0]      o_bins_used
);
    import itb_pkg::*;

    logic [TIME_W-1:0]  mem_st [MAX_INTERVALS];
    logic [TIME_W-1:0]  mem_en [MAX_INTERVALS];
    logic [METH_W-1:0]  mem_m  [MAX_INTERVALS];
    logic [TOTAL_W-1:0] mem_tab [TAB_DEPTH];

    t_op                r_op;
    logic [METH_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_st, r_en;
    logic [BIN_W-1:0]   r_bi;
    logic [CNT_W-1:0]   r_count;
    logic [TIME_W-1:0]  r_es, r_le;
    logic               r_tab_ready;
    logic [TAB_W-1:0]   r_sweep;
    logic [WIDE_W-1:0]  r_acc, r_lim, r_lo, r_hi;
    logic [USED_W-1:0]  r_n;
    logic [IDX_W-1:0]   r_k;
    logic [TIME_W-1:0]  r_mst, r_men, r_ist, r_ien;
    logic [METH_W-1:0]  r_mm, r_im;
    logic [BIN_W-1:0]   r_b;
    logic [SIZE_W-1:0]  r_ov;
    logic               r_dropped;
    logic [TOTAL_W-1:0] r_tab_q;
    logic [1:0]         r_res_status, r_out_status;
    logic [TOTAL_W-1:0] r_res_total, r_out_total;
    logic [USED_W-1:0]  r_res_used, r_out_used;

    logic [SIZE_W-1:0]  bs;
    logic [WIDE_W-1:0]  bs_w, span_w, a_w, z_w, ist_w, ien_w;
    logic [TAB_W-1:0]   tab_raddr;
    logic [TOTAL_W:0]   sum;
    logic               full, grow;

    assign bs     = (i_bin_size == '0) ? SIZE_W'(1) : i_bin_size;
    assign bs_w   = WIDE_W'(bs);
    assign span_w = WIDE_W'(r_le - r_es);
    assign full   = (r_count == CNT_W'(MAX_INTERVALS));
    assign grow   = (r_acc < span_w) && (r_n < USED_W'(NUM_BINS));
    assign ist_w  = WIDE_W'(r_ist);
    assign ien_w  = WIDE_W'(r_ien);
    assign a_w    = (ist_w > r_lo) ? ist_w : r_lo;
    assign z_w    = (ien_w < r_hi) ? ien_w : r_hi;
    assign tab_raddr = i_cmd.bin_rd ? {r_im, r_b} : {r_slot, r_bi};
    assign sum    = {1'b0, r_tab_q} + (TOTAL_W+1)'(r_ov);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_es        <= '1;
            r_le        <= '0;
            r_tab_ready <= 1'b0;
        end else begin
            if (i_cmd.rec && !full) begin
                if (r_count == '0 || r_st < r_es) r_es <= r_st;
                if (r_count == '0 || r_en > r_le) r_le <= r_en;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.clr) begin
                r_count <= '0;
                r_es    <= '1;
                r_le    <= '0;
            end
            if (i_cmd.fin_done) r_tab_ready <= 1'b1;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec && !full) begin
            mem_st[r_count[IDX_W-1:0]] <= r_st;
            mem_en[r_count[IDX_W-1:0]] <= r_en;
            mem_m[r_count[IDX_W-1:0]]  <= r_slot;
        end
        if (i_cmd.int_rd) begin
            r_mst <= mem_st[r_k];
            r_men <= mem_en[r_k];
            r_mm  <= mem_m[r_k];
        end
        if (i_cmd.sweep) mem_tab[r_sweep] <= '0;
        else if (i_cmd.bin_wr) mem_tab[{r_im, r_b}] <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        r_tab_q <= mem_tab[tab_raddr];
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_opcode);
            r_slot <= i_method_slot;
            r_st   <= i_start_time;
            r_en   <= (i_end_time < i_start_time) ? i_start_time : i_end_time;
            r_bi   <= i_bin_index;
        end
        if (i_cmd.rec) begin
            r_res_status <= full ? ST_FULL : ST_OK;
            r_res_total  <= '0;
            r_res_used   <= '0;
        end
        if (i_cmd.clr) begin
            r_res_status <= ST_OK;
            r_res_total  <= '0;
            r_res_used   <= '0;
        end
        if (i_cmd.rd_cap) begin
            r_res_status <= r_tab_ready ? ST_OK : ST_NOT_FIN;
            r_res_total  <= r_tab_ready ? r_tab_q : '0;
            r_res_used   <= '0;
        end
        if (i_cmd.sweep_init) begin
            r_sweep   <= '0;
            r_acc     <= '0;
            r_n       <= '0;
            r_k       <= '0;
            r_dropped <= 1'b0;
            r_lim     <= WIDE_W'(r_es) + WIDE_W'({bs, {BIN_W{1'b0}}});
        end
        if (i_cmd.sweep) r_sweep <= r_sweep + TAB_W'(1);
        if (i_cmd.used_step && grow) begin
            r_acc <= r_acc + bs_w;
            r_n   <= r_n + USED_W'(1);
        end
        if (i_cmd.int_load) begin
            r_ist <= r_mst;
            r_ien <= r_men;
            r_im  <= r_mm;
            r_b   <= '0;
            r_lo  <= WIDE_W'(r_es);
            r_hi  <= WIDE_W'(r_es) + bs_w;
            // overlap past the last bin is dropped
            if (r_men > r_mst && WIDE_W'(r_men) > r_lim) r_dropped <= 1'b1;
        end
        if (i_cmd.bin_rd) r_ov <= (z_w > a_w) ? SIZE_W'(z_w - a_w) : '0;
        if (i_cmd.bin_wr) begin
            r_b  <= r_b + BIN_W'(1);
            r_lo <= r_lo + bs_w;
            r_hi <= r_hi + bs_w;
            if (r_b == BIN_W'(NUM_BINS - 1)) r_k <= r_k + IDX_W'(1);
        end
        if (i_cmd.fin_done) begin
            r_res_status <= r_dropped ? ST_DROPPED : ST_OK;
            r_res_total  <= '0;
            r_res_used   <= (r_count == '0) ? '0 : r_n;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_total  <= r_res_total;
            r_out_used   <= r_res_used;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.sweep_last = (r_sweep == TAB_W'(TAB_DEPTH - 1));
    assign o_sts.used_done  = !grow;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.b_last     = (r_b == BIN_W'(NUM_BINS - 1));
    assign o_sts.k_last     = (CNT_W'(r_k) + CNT_W'(1) == r_count);

    assign o_status    = r_out_status;
    assign o_bin_total = r_out_total;
    assign o_bins_used = r_out_used;

endmodule

// ----- hdl/interval_time_binning_top.sv -----
// Interval time binning: the bin-size register port and the two channels.
// Depends on itb_pkg, itb_if, itb_ctrl and itb_dp.
//
// One item is worked at a time and yields one result beat. Record and clear
// pass from accept through the execute state to the response state; a read
// adds a table-read state between them. A finish clears the time table one
// entry a cycle, finds the bin count by repeated adds of the bin size, and
// walks every stored interval through all 64 bins with a read and then a
// write of the time table. The next item is taken while a result still
// waits in the output register.
module interval_time_binning_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    itb_in_if.sink                         i_in,
    itb_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [itb_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import itb_pkg::*;

    logic [SIZE_W-1:0] r_bin_size;
    t_cmd              cmd;
    t_sts              sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_size <= SIZE_W'(1);
        end else if (psel && penable && pwrite && paddr == REG_BIN_SIZE) begin
            r_bin_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BIN_SIZE) ? 32'(r_bin_size) : '0;

    itb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    itb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_bin_size    (r_bin_size),
        .i_opcode      (i_in.opcode),
        .i_method_slot (i_in.method_slot),
        .i_start_time  (i_in.start_time),
        .i_end_time    (i_in.end_time),
        .i_bin_index   (i_in.bin_index),
        .o_status      (o_out.status),
        .o_bin_total   (o_out.bin_total),
        .o_bins_used   (o_out.bins_used)
    );

endmodule

// ----- bench/tb_interval_time_binning_top.sv -----
// Self-checking bench for interval_time_binning_top: directed table, then random phases.
// Depends on itb_pkg, itb_if and the interval_time_binning_top RTL.
`timescale 1ns / 1ps

module tb_interval_time_binning_top;
    import itb_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_BIN_SIZE = ADDR_W'(4 * REG_BIN_SIZE);
    localparam logic [ADDR_W-1:0] ADDR_SPARE    = 3'd4;  // no register here
    localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX      = {SIZE_W{1'b1}};
    localparam longint unsigned   SAT           = 64'hFFFF_FFFF;

    typedef struct {
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total;
        logic [USED_W-1:0]  used;
    } t_result;

    typedef struct {
        t_op                op;
        logic [METH_W-1:0]  slot;
        logic [TIME_W-1:0]  st;
        logic [TIME_W-1:0]  en;
        logic [BIN_W-1:0]   bin;
        bit                 typed;
        t_result            res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    itb_in_if  in_if ();
    itb_out_if out_if ();

    interval_time_binning_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic [TIME_W-1:0]  m_starts  [MAX_INTERVALS];
    logic [TIME_W-1:0]  m_ends    [MAX_INTERVALS];
    logic [METH_W-1:0]  m_methods [MAX_INTERVALS];
    int unsigned        m_count;
    logic [TIME_W-1:0]  m_earliest;
    logic [TIME_W-1:0]  m_latest;
    logic [TOTAL_W-1:0] m_table [TAB_DEPTH];
    bit                 m_ready;
    logic [SIZE_W-1:0]  m_bin_size;

    t_result     pending_results[$];
    int          errors;
    int          n_items, n_finish, n_reads, n_dropped, n_full;
    int          rx_mode;
    bit          hold_on;
    event        hold_go;
    logic [7:0]  rx_pattern = 8'b1101_0110;
    t_row        dir_rows[$];

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        #(12 * 3_000_000);
        $display("run limit reached with %0d results outstanding", pending_results.size());
        $display("interval_time_binning_top: mismatch");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        $display("[%0t] ERROR %s", $realtime, what);
    endtask

    // overlap of one stored interval with the bins it covers; returns 1 when bins were dropped
    function automatic bit bin_one(input int k, input longint unsigned bs);
        longint unsigned st, en, b, last, lo, hi, a, z, s;
        st = m_starts[k];
        en = m_ends[k];
        if (en <= st) return 0;
        b = (st - m_earliest) / bs;
        last = (en - m_earliest - 1) / bs;
        for (; b <= last; b++) begin
            if (b >= NUM_BINS) return 1;
            lo = m_earliest + b * bs;
            hi = lo + bs;
            a = (st > lo) ? st : lo;
            z = (en < hi) ? en : hi;
            if (z > a) begin
                s = m_table[m_methods[k] * NUM_BINS + b] + (z - a);
                m_table[m_methods[k] * NUM_BINS + b] = (s > SAT) ? SAT[31:0] : s[31:0];
            end
        end
        return 0;
    endfunction

    function automatic t_result predict_binning(input t_op op, input logic [METH_W-1:0] slot,
                                                input logic [TIME_W-1:0] st,
                                                input logic [TIME_W-1:0] en,
                                                input logic [BIN_W-1:0] bin);
        t_result r;
        longint unsigned bs, span, need;
        bit dropped;
        r = '{ST_OK, '0, '0};
        case (op)
            OP_RECORD: begin
                if (m_count >= MAX_INTERVALS) begin
                    r.status = ST_FULL;
                end else begin
                    if (en < st) en = st;
                    m_starts[m_count]  = st;
                    m_ends[m_count]    = en;
                    m_methods[m_count] = slot;
                    if (m_count == 0) begin
                        m_earliest = st;
                        m_latest   = en;
                    end else begin
                        if (st < m_earliest) m_earliest = st;
                        if (en > m_latest) m_latest = en;
                    end
                    m_count++;
                end
            end
            OP_FINISH: begin
                bs = (m_bin_size == 0) ? 1 : m_bin_size;
                dropped = 0;
                foreach (m_table[i]) m_table[i] = '0;
                if (m_count > 0) begin
                    span = longint'(m_latest) - longint'(m_earliest);
                    need = (span + bs - 1) / bs;
                    r.used = (need > NUM_BINS) ? USED_W'(NUM_BINS) : USED_W'(need);
                    for (int k = 0; k < m_count; k++)
                        if (bin_one(k, bs)) dropped = 1;
                end
                r.status = dropped ? ST_DROPPED : ST_OK;
                m_ready = 1;
            end
            OP_READ: begin
                if (!m_ready) r.status = ST_NOT_FIN;
                else r.total = m_table[slot * NUM_BINS + bin];
            end
            default: begin
                m_count    = 0;
                m_earliest = TIME_MAX;
                m_latest   = '0;
            end
        endcase
        return r;
    endfunction

    // result side: compare every beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                t_result e;
                e = pending_results.pop_front();
                if (out_if.status !== e.status)
                    report($sformatf("status %0d, expected %0d", out_if.status, e.status));
                if (out_if.bin_total !== e.total)
                    report($sformatf("bin_total %0d, expected %0d", out_if.bin_total, e.total));
                if (out_if.bins_used !== e.used)
                    report($sformatf("bins_used %0d, expected %0d", out_if.bins_used, e.used));
            end
        end
    end

    // receiver stall pattern; a running hold-off overrides it
    always @(posedge i_clk) begin
        rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        if (hold_on) begin
            out_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= ($urandom_range(3) != 0);
                default: out_if.ready <= rx_pattern[0];
            endcase
        end
    end

    // long receiver hold-off, counted here once the main flow starts it
    initial begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bin_size(input logic [31:0] value);
        apb_access(1'b1, ADDR_BIN_SIZE, value);
        m_bin_size = value[SIZE_W-1:0];
        apb_access(1'b0, ADDR_BIN_SIZE, '0);
        if (prdata[SIZE_W-1:0] !== m_bin_size)
            report($sformatf("bin_size reads %0d, expected %0d", prdata, m_bin_size));
    endtask

    // offer one beat, wait for accept, queue the expectation; valid stays high
    task automatic send_item(input t_op op, input logic [METH_W-1:0] slot,
                             input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] en,
                             input logic [BIN_W-1:0] bin, input bit typed = 0,
                             input t_result typed_res = '{ST_OK, '0, '0});
        t_result r;
        in_if.valid       <= 1'b1;
        in_if.opcode      <= op;
        in_if.method_slot <= slot;
        in_if.start_time  <= st;
        in_if.end_time    <= en;
        in_if.bin_index   <= bin;
        do @(posedge i_clk); while (!in_if.ready);
        r = predict_binning(op, slot, st, en, bin);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
        n_items++;
        if (op == OP_FINISH) begin
            n_finish++;
            if (r.status == ST_DROPPED) n_dropped++;
        end
        if (op == OP_READ) n_reads++;
        if (r.status == ST_FULL) n_full++;
    endtask

    // bursty sender: sometimes drop valid between items
    task automatic maybe_gap();
        int n;
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 6);
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int guard;
        in_if.valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] clamp_time(input longint unsigned v);
        return (v > TIME_MAX) ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    // one collect / finish / read-back phase with random content
    task automatic run_phase(input int n_rec);
        longint unsigned bs, base, st, en;
        logic [METH_W-1:0] used_slots[$];
        int pick;
        bs = (m_bin_size == 0) ? 1 : m_bin_size;
        case ($urandom_range(3))
            0:       base = $urandom_range(0, 1000);
            1:       base = {1'b1, 30'($urandom())};
            default: base = 31'($urandom());
        endcase
        for (int i = 0; i < n_rec; i++) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
                send_item(OP_READ, 4'($urandom()), '0, '0, 6'($urandom()));
            end else if (pick == 1 && i > 2 && n_rec < MAX_INTERVALS) begin
                // long phases fill the store, so they never clear it midway
                send_item(OP_CLEAR, 4'($urandom()), 31'($urandom()), 31'($urandom()),
                          6'($urandom()));
            end else if (pick == 2) begin
                send_item(OP_RECORD, 4'($urandom()), 31'($urandom()), 31'($urandom()),
                          6'($urandom()));
            end else begin
                st = clamp_time(base + $urandom_range(0, 32'(bs * 40)));
                en = clamp_time(st + $urandom_range(0, 32'(bs * 30)));
                if (pick == 3) en = (st > 5) ? st - $urandom_range(1, 5) : 0;
                used_slots.insert(used_slots.size(), 4'($urandom()));
                send_item(OP_RECORD, used_slots[$], st[TIME_W-1:0], en[TIME_W-1:0],
                          6'($urandom()));
            end
            maybe_gap();
        end
        send_item(OP_FINISH, 4'($urandom()), 31'($urandom()), 31'($urandom()),
                  6'($urandom()));
        maybe_gap();
        repeat ($urandom_range(6, 16)) begin
            if (used_slots.size() != 0 && $urandom_range(3) != 0)
                send_item(OP_READ, used_slots[$urandom_range(used_slots.size() - 1)],
                          31'($urandom()), 31'($urandom()), 6'($urandom_range(0, 40)));
            else
                send_item(OP_READ, 4'($urandom()), '0, '0, 6'($urandom()));
            maybe_gap();
        end
        // record after finish keeps the table
        send_item(OP_RECORD, 4'($urandom()), 31'(base), 31'(base + 1), '0);
        send_item(OP_READ, used_slots.size() ? used_slots[0] : 4'd0, '0, '0, 6'd0);
        send_item(OP_CLEAR, '0, '0, '0, '0);
    endtask

    initial begin
        t_row row;
        logic [31:0] sizes[$];
        int phase;
        errors = 0;
        n_items = 0; n_finish = 0; n_reads = 0; n_dropped = 0; n_full = 0;
        rx_mode = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_if.valid = 1'b0; in_if.opcode = OP_RECORD; in_if.method_slot = '0;
        in_if.start_time = '0; in_if.end_time = '0; in_if.bin_index = '0;
        foreach (m_table[i]) m_table[i] = '0;
        m_count = 0; m_earliest = TIME_MAX; m_latest = '0; m_ready = 0; m_bin_size = 1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, bin size 1 after reset
        dir_rows = '{
            '{OP_READ,   4'd0,  31'd0,    31'd0,    6'd0,  1, '{ST_NOT_FIN, 0, 0}},
            '{OP_FINISH, 4'd0,  31'd0,    31'd0,    6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_READ,   4'd15, 31'd0,    31'd0,    6'd63, 1, '{ST_OK, 0, 0}},
            '{OP_RECORD, 4'd0,  31'd10,   31'd20,   6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_RECORD, 4'd3,  31'd15,   31'd5,    6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_RECORD, 4'd15, 31'd12,   31'd90,   6'd63, 1, '{ST_OK, 0, 0}},
            '{OP_FINISH, 4'd0,  31'd0,    31'd0,    6'd0,  0, '{ST_OK, 0, 0}},
            '{OP_READ,   4'd0,  31'd0,    31'd0,    6'd0,  0, '{ST_OK, 0, 0}},
            '{OP_READ,   4'd15, 31'd0,    31'd0,    6'd63, 0, '{ST_OK, 0, 0}},
            '{OP_READ,   4'd3,  31'd0,    31'd0,    6'd5,  0, '{ST_OK, 0, 0}},
            '{OP_CLEAR,  4'd15, TIME_MAX, TIME_MAX, 6'd63, 1, '{ST_OK, 0, 0}},
            '{OP_FINISH, 4'd0,  31'd0,    31'd0,    6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_RECORD, 4'd7,  TIME_MAX, TIME_MAX, 6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_RECORD, 4'd0,  31'd0,    TIME_MAX, 6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_FINISH, 4'd0,  31'd0,    31'd0,    6'd0,  1, '{ST_DROPPED, 0, 64}},
            '{OP_READ,   4'd0,  31'd0,    31'd0,    6'd63, 1, '{ST_OK, 1, 0}},
            '{OP_READ,   4'd7,  31'd0,    31'd0,    6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_RECORD, 4'd9,  31'd100,  31'd200,  6'd0,  1, '{ST_OK, 0, 0}},
            '{OP_READ,   4'd0,  31'd0,    31'd0,    6'd0,  1, '{ST_OK, 1, 0}}
        };
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_item(row.op, row.slot, row.st, row.en, row.bin, row.typed, row.res);
        end
        drain();

        // writes to the empty address must leave bin_size alone
        apb_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
        sizes = '{32'd0, 32'd1, 32'd1048576, 32'(SIZE_MAX), 32'd3, 32'd17, 32'd1000};

        phase = 0;
        while (n_items < 600) begin
            if (phase < sizes.size()) set_bin_size(sizes[phase]);
            else if ($urandom_range(2) == 0) set_bin_size(sizes[$urandom_range(sizes.size() - 1)]);
            else set_bin_size($urandom_range(1, 200));
            rx_mode = $urandom_range(2);
            if (phase == 2) begin
                // long receiver hold-off while items keep coming
                -> hold_go;
                run_phase(20);
            end else if (phase == 4) begin
                run_phase(MAX_INTERVALS + 40);
            end else begin
                run_phase($urandom_range(1, 20));
            end
            drain();
            phase++;
        end

        in_if.valid <= 1'b0;
        drain();
        $display("%0d items over %0d phases: %0d finishes (%0d with dropped bins), %0d reads,",
                 n_items, phase, n_finish, n_dropped, n_reads);
        $display("%0d records refused with the store full, %0d bad fields", n_full, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("interval_time_binning_top: match");
        end else begin
            $display("interval_time_binning_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/itb_pkg.sv
hdl/itb_if.sv
hdl/itb_ctrl.sv
hdl/itb_dp.sv
hdl/interval_time_binning_top.sv
bench/tb_interval_time_binning_top.sv
